@@ design/sccq_pkg.sv @@
// sccq_pkg: shared types, scancode constants and the set 1 keymap for the
// scancode-to-character queue. No dependencies.
package sccq_pkg;

  // Item kinds carried on the input tuser
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CODE = 2'd2;

  // Scancode set 1 special bytes
  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_UP         = 8'h48;
  localparam logic [7:0] SC_DOWN       = 8'h50;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;

  localparam int unsigned KEYMAP_LEN = 58;

  // Reset values of the arrow codes
  localparam logic [7:0] UP_CODE_RST   = 8'h80;
  localparam logic [7:0] DOWN_CODE_RST = 8'h81;

  // Unshifted half of the keymap
  localparam logic [7:0] KEYMAP_LO [0:KEYMAP_LEN-1] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Shifted half of the keymap
  localparam logic [7:0] KEYMAP_HI [0:KEYMAP_LEN-1] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Decoder result for one scancode byte
  typedef struct packed {
    logic       have;
    logic [7:0] ch;
    logic       shift_nxt;
    logic       prefix_nxt;
  } sccq_dec_t;

  // Queue request from the top level
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } sccq_req_t;

  // Queue outcome of one request
  typedef struct packed {
    logic pushed;
    logic dropped;
    logic popped;
  } sccq_stat_t;

endpackage

@@ design/scancode_to_char_queue.sv @@
// scancode_to_char_queue: top level; input register, scancode decoder,
// character queue and result register. Depends on sccq_pkg, sccq_decode, sccq_fifo.
//
//  port group | direction | contents
//  in_*       | sink      | tdata[7:0] scan_byte; tuser[0] opcode, tuser[1] from_mouse
//  out_*      | source    | tdata[7:0] read_char; tuser[0] read_valid,
//             |           |   tuser[1] char_queued, tuser[2] char_dropped
//  cfg_*      | write     | index 0 decoder_enable, 1 up_arrow_code, 2 down_arrow_code
//
// One item per cycle sustained while out_tready stays high; an item passes the
// input register, then decode plus queue access into the result register, whose
// read data comes from the registered memory port.
// Reset (rst_n low, synchronous) empties the queue and clears the flags; no
// clearing pass. A stalled result holds the item in the input register and
// drops in_tready; both stages refill in the cycle the result is taken.
module scancode_to_char_queue #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] scan_byte
  input  logic [1:0]                     in_tuser,   // [0] opcode, [1] from_mouse
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] read_char
  output logic [2:0]                     out_tuser,  // [0] read_valid, [1] char_queued,
                                                     // [2] char_dropped
  input  logic                           cfg_wr_en,
  input  logic [sccq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wr_data
);
  import sccq_pkg::*;

  logic       enable_r;
  logic [7:0] up_code_r, down_code_r;
  logic       shift_r, prefix_r;
  logic       in_valid_r, op_r, mouse_r;
  logic [7:0] byte_r;
  logic       out_valid_r, read_valid_r, queued_r, dropped_r;
  logic       advance, scan_en;
  logic [7:0] rd_data;
  sccq_dec_t  dec;
  sccq_req_t  req;
  sccq_stat_t stat;

  // Move the held item into the result register when that register frees up
  assign advance   = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;
  assign scan_en   = (op_r == OP_SCAN) & enable_r & ~mouse_r;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      up_code_r   <= UP_CODE_RST;
      down_code_r <= DOWN_CODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE:    enable_r    <= cfg_wr_data[0];
        CFG_UP_CODE:   up_code_r   <= cfg_wr_data;
        CFG_DOWN_CODE: down_code_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r  <= in_tdata;
      op_r    <= in_tuser[0];
      mouse_r <= in_tuser[1];
    end
  end

  sccq_decode u_decode (
    .scan_byte   (scan_en),
    .byte_in     (byte_r),
    .shift_held  (shift_r),
    .prefix_seen (prefix_r),
    .up_code     (up_code_r),
    .down_code   (down_code_r),
    .dec         (dec)
  );

  assign req.push = scan_en & dec.have;
  assign req.pop  = (op_r == OP_READ);
  assign req.data = dec.ch;

  sccq_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .req       (req),
    .stat      (stat),
    .rd_data_r (rd_data)
  );

  // Update decoder flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      prefix_r <= 1'b0;
    end else if (advance) begin
      shift_r  <= dec.shift_nxt;
      prefix_r <= dec.prefix_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      read_valid_r <= 1'b0;
      queued_r     <= 1'b0;
      dropped_r    <= 1'b0;
    end else if (advance) begin
      out_valid_r  <= 1'b1;
      read_valid_r <= stat.popped;
      queued_r     <= stat.pushed;
      dropped_r    <= stat.dropped;
    end else if (out_tready) begin
      out_valid_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = read_valid_r ? rd_data : 8'h00;
  assign out_tuser  = {dropped_r, queued_r, read_valid_r};

  // At most one outcome flag per result
  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser))
    else $error("more than one result flag set");

  // A held item is kept while the result side stalls
  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("held item lost during a stall");

  // Flags move only when an item advances
  a_flags_still: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(shift_r) && $stable(prefix_r)))
    else $error("decoder flags changed without an item");

endmodule

@@ design/sccq_decode.sv @@
// sccq_decode: combinational scancode set 1 decoder (prefix, shift, keymap).
// Depends on sccq_pkg.
module sccq_decode (
  input  logic                scan_byte,
  input  logic [7:0]          byte_in,
  input  logic                shift_held,
  input  logic                prefix_seen,
  input  logic [7:0]          up_code,
  input  logic [7:0]          down_code,
  output sccq_pkg::sccq_dec_t dec
);
  import sccq_pkg::*;

  logic       in_table;
  logic [5:0] idx;
  logic [7:0] key_ch;

  // Look up the keymap half picked by the shift flag
  assign in_table = (byte_in < 8'(KEYMAP_LEN));
  assign idx      = byte_in[5:0];
  assign key_ch   = in_table ? (shift_held ? KEYMAP_HI[idx] : KEYMAP_LO[idx]) : 8'h00;

  // Update flags and pick the character
  always_comb begin
    dec.have       = 1'b0;
    dec.ch         = 8'h00;
    dec.shift_nxt  = shift_held;
    dec.prefix_nxt = prefix_seen;
    if (scan_byte) begin
      if (byte_in == SC_PREFIX) begin
        dec.prefix_nxt = 1'b1;
      end else if (prefix_seen) begin
        dec.prefix_nxt = 1'b0;
        if (byte_in == SC_UP) begin
          dec.have = 1'b1;
          dec.ch   = up_code;
        end else if (byte_in == SC_DOWN) begin
          dec.have = 1'b1;
          dec.ch   = down_code;
        end
      end else if (byte_in == SC_LSHIFT || byte_in == SC_RSHIFT) begin
        dec.shift_nxt = 1'b1;
      end else if (byte_in == SC_LSHIFT_BRK || byte_in == SC_RSHIFT_BRK) begin
        dec.shift_nxt = 1'b0;
      end else begin
        dec.have = (key_ch != 8'h00);
        dec.ch   = key_ch;
      end
    end
  end

endmodule

@@ design/sccq_fifo.sv @@
// sccq_fifo: circular character queue holding up to QUEUE_DEPTH-1 entries,
// with registered read data. Depends on sccq_pkg.
module sccq_fifo #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  sccq_pkg::sccq_req_t  req,
  output sccq_pkg::sccq_stat_t stat,
  output logic [7:0]           rd_data_r
);
  import sccq_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic             empty, full;

  // Advance pointers with wrap at the queue depth
  assign wr_inc = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
  assign empty  = (wr_ptr_r == rd_ptr_r);
  assign full   = (wr_inc == rd_ptr_r);

  always_comb begin
    stat.pushed  = req.push & ~full;
    stat.dropped = req.push & full;
    stat.popped  = req.pop & ~empty;
    wr_ptr_nxt   = stat.pushed ? wr_inc : wr_ptr_r;
    rd_ptr_nxt   = stat.popped ? rd_inc : rd_ptr_r;
  end

  // Hold the pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (advance) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Write and read the character store
  always_ff @(posedge clk) begin
    if (advance && stat.pushed) begin
      mem[wr_ptr_r] <= req.data;
    end
    if (advance && stat.popped) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // A drop leaves the write pointer alone
  a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stat.dropped) |=> (wr_ptr_r == $past(wr_ptr_r)))
    else $error("write pointer moved on a dropped character");

endmodule

@@ tb/sv/scancode_char_checker.sv @@
`timescale 1ns / 100ps
// scancode_char_checker: watches the item, result and register ports of
// scancode_to_char_queue, predicts each result and compares it. Depends on sccq_pkg.
module scancode_char_checker #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,     // [7:0] scan_byte
  input  logic [1:0]                     in_tuser,     // [0] opcode, [1] from_mouse
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [7:0]                     out_tdata,    // [7:0] read_char
  input  logic [2:0]                     out_tuser,    // [0] read_valid, [1] char_queued,
                                                       // [2] char_dropped
  input  logic                           cfg_wr_en,
  input  logic [sccq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wr_data,
  output int                             fail_count,
  output int                             results_due
);
  import sccq_pkg::*;

  typedef struct packed {
    logic [7:0] read_char;
    logic       read_valid;
    logic       char_queued;
    logic       char_dropped;
  } char_result_t;

  // Set 1 keymap, plain half
  localparam logic [7:0] PLAIN_KEYS [KEYMAP_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // Set 1 keymap, shifted half
  localparam logic [7:0] SHIFTED_KEYS [KEYMAP_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  logic               decode_on;
  logic [7:0]         up_code;
  logic [7:0]         down_code;
  logic               shift_down;
  logic               prefix_pending;
  logic [7:0]         queued_chars [$];
  char_result_t       due_results [$];
  int                 errors = 0;

  // Decode one item against the mirrored flags and character queue
  function automatic char_result_t decode_item(logic opcode, logic [7:0] code, logic mouse);
    char_result_t res;
    logic         produced;
    logic [7:0]   ch;
    res      = '0;
    produced = 1'b0;
    ch       = 8'h00;
    if (opcode == OP_READ) begin
      if (queued_chars.size() != 0) begin
        res.read_char  = queued_chars.pop_front();
        res.read_valid = 1'b1;
      end
      return res;
    end
    if (!decode_on || mouse)
      return res;
    if (code == SC_PREFIX) begin
      prefix_pending = 1'b1;
    end else if (prefix_pending) begin
      if (code == SC_UP) begin
        ch       = up_code;
        produced = 1'b1;
      end else if (code == SC_DOWN) begin
        ch       = down_code;
        produced = 1'b1;
      end
      prefix_pending = 1'b0;
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_down = 1'b1;
    end else if (code == SC_LSHIFT_BRK || code == SC_RSHIFT_BRK) begin
      shift_down = 1'b0;
    end else if (code < KEYMAP_LEN) begin
      ch       = shift_down ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
      produced = (ch != 8'h00);
    end
    // Store or drop; the queue holds one less than its depth
    if (produced) begin
      if (queued_chars.size() < QUEUE_DEPTH - 1) begin
        queued_chars.push_back(ch);
        res.char_queued = 1'b1;
      end else begin
        res.char_dropped = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    char_result_t want;
    char_result_t got;
    if (!rst_n) begin
      decode_on      = 1'b0;
      up_code        = UP_CODE_RST;
      down_code      = DOWN_CODE_RST;
      shift_down     = 1'b0;
      prefix_pending = 1'b0;
      queued_chars.delete();
      due_results.delete();
    end else begin
      // Match each taken result against the oldest prediction
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser[0], out_tuser[1], out_tuser[2]};
        if (due_results.size() == 0) begin
          note_failure($sformatf("result with none due: char %h valid %b queued %b dropped %b",
                                 got.read_char, got.read_valid, got.char_queued,
                                 got.char_dropped));
        end else begin
          want = due_results.pop_front();
          if (got.read_char !== want.read_char || got.read_valid !== want.read_valid ||
              got.char_queued !== want.char_queued || got.char_dropped !== want.char_dropped)
            note_failure($sformatf({"result mismatch: expected char %h valid %b queued %b ",
                                    "dropped %b, got char %h valid %b queued %b dropped %b"},
                                   want.read_char, want.read_valid, want.char_queued,
                                   want.char_dropped, got.read_char, got.read_valid,
                                   got.char_queued, got.char_dropped));
        end
      end
      // Predict each accepted item
      if (in_tvalid && in_tready)
        due_results.push_back(decode_item(in_tuser[0], in_tdata, in_tuser[1]));
      // Mirror register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLE:    decode_on = cfg_wr_data[0];
          CFG_UP_CODE:   up_code   = cfg_wr_data;
          CFG_DOWN_CODE: down_code = cfg_wr_data;
          default: ;
        endcase
      end
    end
    fail_count  <= errors;
    results_due <= due_results.size();
  end

endmodule

@@ tb/sv/scancode_to_char_queue_tb.sv @@
`timescale 1ns / 100ps
// scancode_to_char_queue_tb: clock, reset, scancode and read stimulus, register
// setup and verdict. Depends on sccq_pkg, scancode_char_checker and the block.
module scancode_to_char_queue_tb;
  import sccq_pkg::*;

  localparam int unsigned DEPTH = 256;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata    = 8'h00;  // [7:0] scan_byte
  logic [1:0]           in_tuser    = 2'b00;  // [0] opcode, [1] from_mouse
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [7:0]           out_tdata;            // [7:0] read_char
  logic [2:0]           out_tuser;            // [0] read_valid, [1] char_queued,
                                              // [2] char_dropped
  logic                 cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = CFG_ENABLE;
  logic [7:0]           cfg_wr_data = 8'h00;
  int                   fail_count;
  int                   results_due;
  logic                 source_fast = 1'b0;
  logic                 sink_fast   = 1'b0;
  int                   items_sent  = 0;

  scancode_to_char_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wr_data
  );

  scancode_char_checker #(.QUEUE_DEPTH(DEPTH)) u_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .fail_count, .results_due
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic opcode, logic [7:0] code, logic mouse);
    int gap;
    if ($urandom_range(0, 31) == 0)
      source_fast = ~source_fast;
    gap = source_fast ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= {mouse, opcode};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_scan(logic [7:0] code, logic mouse = 1'b0);
    send_item(OP_SCAN, code, mouse);
  endtask

  task automatic send_read();
    send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic en, logic [7:0] up, logic [7:0] down);
    write_reg(CFG_ENABLE, {7'd0, en});
    write_reg(CFG_UP_CODE, up);
    write_reg(CFG_DOWN_CODE, down);
  endtask

  // One random keystroke sequence, mostly well formed, some noise
  task automatic send_keystroke();
    logic [7:0] key;
    key = 8'($urandom_range(0, KEYMAP_LEN - 1));
    case ($urandom_range(0, 11))
      0, 1, 2, 3: send_scan(key);
      4: begin
        send_scan($urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT);
        send_scan(key);
        send_scan($urandom_range(0, 1) ? SC_LSHIFT_BRK : SC_RSHIFT_BRK);
      end
      5: begin
        send_scan(SC_PREFIX);
        send_scan($urandom_range(0, 1) ? SC_UP : SC_DOWN);
      end
      6: begin
        send_scan(SC_PREFIX);
        send_scan(8'($urandom_range(0, 255)));
      end
      7: send_scan(key | 8'h80);
      8: send_scan(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      default: send_read();
    endcase
  endtask

  // Take results after random stalls
  initial begin : sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0)
        sink_fast = ~sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Decoder off after reset: scancode ignored, read on empty queue
    send_scan(8'h10);
    send_read();
    wait_idle();

    // Enable only, arrow codes at their reset values
    write_reg(CFG_ENABLE, 8'h01);
    send_scan(SC_PREFIX);
    send_scan(SC_UP);
    send_scan(SC_PREFIX);
    send_scan(SC_DOWN);
    wait_idle();

    // Arrow codes at the extremes; repeated prefix, prefix then other byte
    set_config(1'b1, 8'h00, 8'hFF);
    send_scan(SC_PREFIX);
    send_scan(SC_PREFIX);
    send_scan(SC_UP);
    send_scan(SC_PREFIX);
    send_scan(SC_DOWN);
    send_scan(SC_PREFIX);
    send_scan(SC_LSHIFT);
    send_scan(8'h10);
    // Keymap edges, out of range, break code, shift keys, mouse byte
    send_scan(8'h00);
    send_scan(8'h01);
    send_scan(8'h39);
    send_scan(8'h3A);
    send_scan(8'h9E);
    send_scan(SC_LSHIFT);
    send_scan(8'h10);
    send_scan(SC_LSHIFT_BRK);
    send_scan(SC_RSHIFT);
    send_scan(8'h02);
    send_scan(SC_RSHIFT_BRK);
    send_scan(8'h10, 1'b1);
    // Pop everything and one more on empty
    repeat (10) send_read();
    wait_idle();

    // Fill past full, then drain past empty
    set_config(1'b1, 8'hFF, 8'h00);
    repeat (300) send_scan(8'($urandom_range(2, 11)));
    repeat (DEPTH) send_read();
    wait_idle();

    // Random traffic across several register settings
    phase = 0;
    while (items_sent < 1150) begin
      case (phase % 4)
        0: set_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        1: set_config(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        2: set_config(1'b1, 8'h00, 8'h00);
        default: set_config(1'b1, 8'hFF, 8'hFF);
      endcase
      repeat ((phase % 4) == 1 ? 15 : 60) send_keystroke();
      wait_idle();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sccq_pkg.sv
design/sccq_decode.sv
design/sccq_fifo.sv
design/scancode_to_char_queue.sv
tb/sv/scancode_char_checker.sv
tb/sv/scancode_to_char_queue_tb.sv
